[src/dq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types for the double-ended queue: operation codes, status codes
// and controller states.
// ----------------------------------------------------------------------------
package dq_pkg;

   // operation requested by one request
   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_CLEAR      = 3'd4
   } mode_type;

   // outcome reported with each result
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_READ = 2'd1,
      S_RESP = 2'd2
   } state_type;

   localparam int COUNT_W = 5;
   localparam int WORD_W  = 32;

endpackage

[src/double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words held in a ring memory.
// ----------------------------------------------------------------------------
// Each request pushes at the front or back, pops from the front or back, or
// clears the store, and returns one result carrying the front and back words,
// the entry count, an empty flag and a status. The pointers and count update
// and any push is written to the ring memory at the edge the request is
// taken; the next cycle reads the new front and back slots through the
// memory's two read ports, and the result is presented the cycle after that.
// A new request is taken in the cycle its predecessor's result is accepted, and
// not before, so requests never overlap. The registered read of the ring memory
// lies between the pointer update and the result. Full pushes and empty pops
// change nothing and are flagged; front and back read zero when the store is
// empty. No clearing pass is needed after reset: only slots holding stored words
// are ever shown.
// ----------------------------------------------------------------------------
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_mode,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_front_value,
   output logic signed [WORD_W-1:0] rsp_back_value,
   output logic [COUNT_W-1:0]       rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic [1:0]               rsp_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   state_type state_ff, state_in;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   status_type       status_ff, status_in;

   logic [WORD_W-1:0] slots_mem [DEPTH];
   logic [WORD_W-1:0] rd_front_ff;
   logic [WORD_W-1:0] rd_back_ff;

   logic             req_accept;
   logic             mem_we;
   logic             mem_re;
   logic [PTR_W-1:0] wr_addr;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] head_prev;
   logic [PTR_W-1:0] tail_next;
   logic [PTR_W-1:0] tail_prev;
   logic             is_full;
   logic             is_empty;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   assign req_accept = req_valid & ~req_stall;

   // ring neighbours of both pointers
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
   assign is_full   = (occ_ff == DEPTH_CNT);
   assign is_empty  = (occ_ff == '0);

   // pointer, count and status update for an accepted request
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      wr_addr   = tail_ff;
      if (req_accept) begin
         status_in = ST_DONE;
         case (mode_type'(req_mode))
            MODE_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  head_in = head_prev;
                  wr_addr = head_prev;
                  mem_we  = 1'b1;
                  occ_in  = occ_ff + 1'b1;
               end
            end
            MODE_PUSH_BACK: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  tail_in = tail_next;
                  wr_addr = tail_ff;
                  mem_we  = 1'b1;
                  occ_in  = occ_ff + 1'b1;
               end
            end
            MODE_POP_FRONT: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  head_in = head_next;
                  occ_in  = occ_ff - 1'b1;
               end
            end
            MODE_POP_BACK: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  tail_in = tail_prev;
                  occ_in  = occ_ff - 1'b1;
               end
            end
            MODE_CLEAR: begin
               head_in = '0;
               tail_in = '0;
               occ_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // controller next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = req_accept ? S_READ : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // controller outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      mem_re    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_READ: begin
            mem_re = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         occ_ff    <= '0;
         status_ff <= ST_DONE;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         status_ff <= status_in;
      end
   end

   // ring memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) slots_mem[wr_addr] <= req_value;
      if (mem_re) begin
         rd_front_ff <= slots_mem[head_ff];
         rd_back_ff  <= slots_mem[tail_prev];
      end
   end

   // result fields
   assign count_wide      = {{COUNT_W{1'b0}}, occ_ff};
   assign rsp_entry_count = count_wide[COUNT_W-1:0];
   assign rsp_is_empty    = is_empty;
   assign rsp_front_value = is_empty ? '0 : rd_front_ff;
   assign rsp_back_value  = is_empty ? '0 : rd_back_ff;
   assign rsp_status      = status_ff;

endmodule
